// File: rtl/dre_pkg.sv
// Shared types, constants and state codes of the delta-row encoder.
// No dependencies; every rtl file refers to it by scoped names.
`default_nettype none

package dre_pkg;

   localparam int BUF_DEPTH       = 8;      // literals per chunk
   localparam int LIT_IDX_W       = 3;      // index into the literal buffer
   localparam int PEND_CNT_W      = 4;      // 0..BUF_DEPTH
   localparam int GAP_W           = 13;     // match gap / offset width
   localparam int LEN_W           = 13;     // encoded length width
   localparam int ROW_BYTES_DEF   = 4096;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [4:0]       OFS_INLINE_MAX = 5'd31;  // offset field in command byte
   localparam logic [7:0]       EXT_MAX        = 8'd255; // largest extension byte
   localparam logic [LEN_W-1:0] LEN_MAX        = 13'h1FFF;

   typedef struct packed {
      logic [7:0] row_byte;
      logic [7:0] seed_byte;
      logic       last_in_row;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             out_valid;
      logic             last_of_run;
      logic             row_done;
      logic [LEN_W-1:0] encoded_length;
   } rsp_type;

   // One unit of work for the back end: a chunk, or an empty row-end marker.
   typedef struct packed {
      logic                            marker;
      logic                            row_end;
      logic [GAP_W-1:0]                offset;
      logic [LIT_IDX_W-1:0]            len_m1;
      logic [BUF_DEPTH-1:0][7:0]       lits;
   } chunk_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CMD,
      BK_EXT,
      BK_LIT,
      BK_MARK
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/dre_front.sv
// Front end: compares row and seed bytes, tracks the match gap and collects
// differing bytes; emits chunk descriptors. Depends on dre_pkg.
`default_nettype none

module dre_front #(
   parameter int ROW_BYTES = dre_pkg::ROW_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire dre_pkg::req_type       req_payload,
   input  wire dre_pkg::q_status_type  q_status,
   output logic                        push,
   output dre_pkg::chunk_type          push_chunk
);

   localparam logic [dre_pkg::GAP_W-1:0] GAP_CAP = dre_pkg::GAP_W'(ROW_BYTES - 1);

   logic [dre_pkg::GAP_W-1:0]      gap_ff, gap_in;
   logic [dre_pkg::PEND_CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                     pend_ff [dre_pkg::BUF_DEPTH];

   logic                           accept;
   logic                           match;
   logic                           chunk;
   logic [dre_pkg::PEND_CNT_W-1:0] cnt_new;
   logic [dre_pkg::GAP_W-1:0]      gap_base;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign match     = (req_payload.row_byte == req_payload.seed_byte);
   assign cnt_new   = cnt_ff + dre_pkg::PEND_CNT_W'(1);

   always_comb begin
      chunk    = 1'b0;
      gap_in   = gap_ff;
      cnt_in   = cnt_ff;
      gap_base = gap_ff;
      push_chunk.marker  = 1'b0;
      push_chunk.row_end = req_payload.last_in_row;
      push_chunk.offset  = gap_ff;
      push_chunk.len_m1  = cnt_ff[dre_pkg::LIT_IDX_W-1:0] - dre_pkg::LIT_IDX_W'(1);
      for (int k = 0; k < dre_pkg::BUF_DEPTH; k++) begin
         push_chunk.lits[k] = pend_ff[k];
      end
      if (match) begin
         // a matching byte closes an open run
         chunk    = (cnt_ff != '0);
         gap_base = chunk ? '0 : gap_ff;
         gap_in   = (gap_base < GAP_CAP) ? gap_base + dre_pkg::GAP_W'(1) : GAP_CAP;
         cnt_in   = '0;
      end else begin
         push_chunk.lits[cnt_ff[dre_pkg::LIT_IDX_W-1:0]] = req_payload.row_byte;
         push_chunk.len_m1 = cnt_ff[dre_pkg::LIT_IDX_W-1:0];
         chunk  = (cnt_new == dre_pkg::PEND_CNT_W'(dre_pkg::BUF_DEPTH))
                  || req_payload.last_in_row;
         cnt_in = chunk ? '0 : cnt_new;
         gap_in = chunk ? '0 : gap_ff;
      end
      push_chunk.marker = !chunk;
      if (req_payload.last_in_row) begin
         gap_in = '0;
         cnt_in = '0;
      end
      push = accept && (chunk || req_payload.last_in_row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
         cnt_ff <= '0;
      end else if (accept) begin
         gap_ff <= gap_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !match) begin
         pend_ff[cnt_ff[dre_pkg::LIT_IDX_W-1:0]] <= req_payload.row_byte;
      end
   end

   a_cnt_below_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < dre_pkg::PEND_CNT_W'(dre_pkg::BUF_DEPTH))
      else $error("pending count reached buffer depth without a chunk");

   a_gap_capped: assert property (@(posedge clock) disable iff (reset)
      gap_ff <= GAP_CAP)
      else $error("match gap above cap");

   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.last_in_row) |-> push)
      else $error("row end without a chunk or marker");

endmodule

`default_nettype wire

// File: rtl/dre_queue.sv
// Small FIFO of chunk descriptors between front and back end.
// Depends on dre_pkg.
`default_nettype none

module dre_queue #(
   parameter int DEPTH = dre_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire dre_pkg::chunk_type    push_chunk,
   input  wire logic                  pop,
   output dre_pkg::chunk_type         head,
   output dre_pkg::q_status_type      q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dre_pkg::chunk_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_chunk;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/dre_back.sv
// Back end: turns chunk descriptors into command, offset extension and literal
// bytes, one per cycle within a chunk unless stalled, through an output register. Depends on dre_pkg.
`default_nettype none

module dre_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dre_pkg::q_status_type q_status,
   input  wire dre_pkg::chunk_type    head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dre_pkg::rsp_type           rsp_payload
);

   dre_pkg::back_state_type        state_ff, state_in;
   dre_pkg::chunk_type             chunk_ff;
   logic [dre_pkg::GAP_W-1:0]      rem_ff, rem_in;
   logic                           zero_ff, zero_in;
   logic [dre_pkg::LIT_IDX_W-1:0]  idx_ff, idx_in;
   logic [dre_pkg::LEN_W-1:0]      row_count_ff, row_count_in;
   dre_pkg::rsp_type               rsp_ff, emit_rsp;
   logic                           rsp_valid_ff;

   logic                           out_ready;
   logic                           emit;
   logic [dre_pkg::LEN_W-1:0]      count_inc;
   logic [4:0]                     first;
   logic [7:0]                     ext;
   logic                           cmd_more;
   logic                           ext_more;
   logic                           lit_last;

   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign count_inc   = (row_count_ff == dre_pkg::LEN_MAX) ? row_count_ff
                        : row_count_ff + dre_pkg::LEN_W'(1);

   // inline part of the offset and the next extension byte
   assign first    = (chunk_ff.offset >= dre_pkg::GAP_W'(dre_pkg::OFS_INLINE_MAX))
                     ? dre_pkg::OFS_INLINE_MAX : chunk_ff.offset[4:0];
   assign ext      = (rem_ff >= dre_pkg::GAP_W'(dre_pkg::EXT_MAX))
                     ? dre_pkg::EXT_MAX : rem_ff[7:0];
   assign cmd_more = (chunk_ff.offset >= dre_pkg::GAP_W'(dre_pkg::OFS_INLINE_MAX));
   assign ext_more = zero_ff ? (rem_ff != '0)
                     : (rem_ff >= dre_pkg::GAP_W'(dre_pkg::EXT_MAX));
   assign lit_last = (idx_ff == chunk_ff.len_m1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dre_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = head.marker ? dre_pkg::BK_MARK : dre_pkg::BK_CMD;
            end
         end
         dre_pkg::BK_CMD: begin
            if (out_ready) state_in = cmd_more ? dre_pkg::BK_EXT : dre_pkg::BK_LIT;
         end
         dre_pkg::BK_EXT: begin
            if (out_ready) state_in = ext_more ? dre_pkg::BK_EXT : dre_pkg::BK_LIT;
         end
         dre_pkg::BK_LIT: begin
            if (out_ready && lit_last) state_in = dre_pkg::BK_IDLE;
         end
         dre_pkg::BK_MARK: begin
            if (out_ready) state_in = dre_pkg::BK_IDLE;
         end
         default: state_in = dre_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop          = 1'b0;
      emit         = 1'b0;
      rem_in       = rem_ff;
      zero_in      = zero_ff;
      idx_in       = idx_ff;
      row_count_in = row_count_ff;
      emit_rsp.out_byte       = '0;
      emit_rsp.out_valid      = 1'b1;
      emit_rsp.last_of_run    = 1'b0;
      emit_rsp.row_done       = 1'b0;
      emit_rsp.encoded_length = count_inc;
      unique case (state_ff)
         dre_pkg::BK_IDLE: begin
            pop    = !q_status.empty;
            idx_in = '0;
         end
         dre_pkg::BK_CMD: begin
            emit              = 1'b1;
            emit_rsp.out_byte = {chunk_ff.len_m1, first};
            rem_in            = chunk_ff.offset - dre_pkg::GAP_W'(first);
            zero_in           = (chunk_ff.offset == dre_pkg::GAP_W'(dre_pkg::OFS_INLINE_MAX));
         end
         dre_pkg::BK_EXT: begin
            emit = 1'b1;
            if (zero_ff) begin
               emit_rsp.out_byte = '0;
               zero_in           = 1'b0;
            end else begin
               emit_rsp.out_byte = ext;
               rem_in            = rem_ff - dre_pkg::GAP_W'(ext);
               zero_in           = (rem_ff == dre_pkg::GAP_W'(dre_pkg::EXT_MAX));
            end
         end
         dre_pkg::BK_LIT: begin
            emit                 = 1'b1;
            emit_rsp.out_byte    = chunk_ff.lits[idx_ff];
            emit_rsp.last_of_run = lit_last;
            emit_rsp.row_done    = lit_last && chunk_ff.row_end;
            idx_in               = idx_ff + dre_pkg::LIT_IDX_W'(1);
         end
         dre_pkg::BK_MARK: begin
            emit                    = 1'b1;
            emit_rsp.out_valid      = 1'b0;
            emit_rsp.last_of_run    = 1'b1;
            emit_rsp.row_done       = 1'b1;
            emit_rsp.encoded_length = row_count_ff;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      if (emit && out_ready) begin
         if (emit_rsp.row_done)       row_count_in = '0;
         else if (emit_rsp.out_valid) row_count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dre_pkg::BK_IDLE;
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         if (out_ready) rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) chunk_ff <= head;
      if (emit && out_ready) begin
         rsp_ff  <= emit_rsp;
         rem_ff  <= rem_in;
         zero_ff <= zero_in;
         idx_ff  <= idx_in;
      end else if (pop) begin
         idx_ff  <= idx_in;
      end
   end

   a_lit_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dre_pkg::BK_LIT) |-> (idx_ff <= chunk_ff.len_m1))
      else $error("literal index past chunk length");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.row_done) |-> rsp_ff.last_of_run)
      else $error("row_done without last_of_run");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit && out_ready && emit_rsp.row_done) |=> (row_count_ff == '0))
      else $error("row length not cleared at row end");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == dre_pkg::BK_IDLE))
      else $error("descriptor taken while busy");

endmodule

`default_nettype wire

// File: rtl/delta_row_encoder.sv
// Delta-row encoder (row against seed row, delta-row compression method 3).
// Top level: front end, descriptor queue and byte-serial back end; uses dre_pkg.
`default_nettype none

// Each input transfer carries one row byte, the seed byte at the same position
// and an end-of-row mark. The front end takes one input per cycle as long as
// the descriptor queue has room; it counts matching bytes and gathers up to
// eight differing bytes. A run closed by a matching byte, a full buffer or the
// row end becomes a chunk descriptor. The back end writes one output byte per
// cycle within a chunk, while the output is not stalled, through a registered
// output: it fetches each descriptor, then sends the command byte, the offset
// extensions and the literals; an empty row-end marker is fetched, then sent as
// one result. The back-end byte sequencer therefore sets the sustained rate; the
// queue (QUEUE_DEPTH descriptors) lets the front keep taking bytes while a
// chunk drains. encoded_length on each result counts the row's bytes so far
// and saturates at 8191; the match gap saturates at ROW_BYTES-1. No state
// needs clearing after reset beyond the control registers.
module delta_row_encoder #(
   parameter int ROW_BYTES   = dre_pkg::ROW_BYTES_DEF,
   parameter int QUEUE_DEPTH = dre_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dre_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dre_pkg::rsp_type       rsp_payload
);

   // front -> queue
   logic                  push;
   dre_pkg::chunk_type    push_chunk;
   // queue -> back
   logic                  pop;
   dre_pkg::chunk_type    head;
   dre_pkg::q_status_type q_status;

   // classify bytes, build descriptors
   dre_front #(
      .ROW_BYTES (ROW_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_chunk  (push_chunk)
   );

   // decouples input acceptance from output drain
   dre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_chunk (push_chunk),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // serialize each descriptor into output transfers
   dre_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: sim/delta_row_encoder_tb.sv
// Self-checking testbench for delta_row_encoder: directed rows, offset coding
// and random rows under idle/stall mixes, checked against a cycle-free encoder predictor.
// Depends on rtl/dre_pkg.sv and rtl/delta_row_encoder.sv.
`default_nettype none

module delta_row_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF  = 6;        // 12 ns period
   localparam int RESET_TICKS = 8;
   localparam int CYCLE_LIMIT = 150_000;  // far beyond the slowest legal run
   localparam int DRAIN_GUARD = 64;       // two queued chunks of 25 bytes plus fetch cycles
   localparam int MAX_SHOWN   = 10;

   // the match gap saturates one short of the row size
   localparam logic [dre_pkg::GAP_W-1:0] GAP_CAP =
      dre_pkg::GAP_W'(dre_pkg::ROW_BYTES_DEF - 1);

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   dre_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   dre_pkg::rsp_type rsp_payload;

   delta_row_encoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Encoder predictor: its own copy of the gap counter, literal buffer and
   // row byte count. Each accepted input transfer appends the bytes it
   // causes to encoded_bytes_q, oldest first.
   // ---------------------------------------------------------------------
   logic [dre_pkg::GAP_W-1:0] gap_count = '0;
   logic [7:0]                lit_buf [dre_pkg::BUF_DEPTH];
   int unsigned               lit_count = 0;
   logic [dre_pkg::LEN_W-1:0] row_len = '0;
   dre_pkg::rsp_type          encoded_bytes_q [$];

   // Knobs shared by the sender, the receiver and the tests.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_off_left = 0;   // receiver holds rsp_stall high while nonzero
   int fail_count    = 0;
   int cycle_count   = 0;

   function automatic void emit_byte(input logic [7:0] value);
      dre_pkg::rsp_type r;
      if (row_len != dre_pkg::LEN_MAX) row_len++;   // length saturates at 8191
      r                = '0;
      r.out_byte       = value;
      r.out_valid      = 1'b1;
      r.encoded_length = row_len;
      encoded_bytes_q.push_back(r);
   endfunction

   // Command byte, offset extension bytes, then the buffered literals.
   function automatic void emit_chunk();
      int unsigned rest;
      int unsigned ext;
      int unsigned k;
      logic [4:0]  inline_ofs;
      if (lit_count == 0) return;
      rest       = 32'(gap_count);
      inline_ofs = (rest < dre_pkg::OFS_INLINE_MAX) ? 5'(rest) : dre_pkg::OFS_INLINE_MAX;
      emit_byte({3'(lit_count - 1), inline_ofs});
      // an offset of exactly 31 needs a zero extension to terminate it
      if (rest == dre_pkg::OFS_INLINE_MAX) emit_byte(8'd0);
      rest -= inline_ofs;
      while (rest > 0) begin
         ext = (rest < dre_pkg::EXT_MAX) ? rest : dre_pkg::EXT_MAX;
         emit_byte(8'(ext));
         // a full 255 extension with nothing left is closed by a zero
         if (rest == dre_pkg::EXT_MAX) emit_byte(8'd0);
         rest -= ext;
      end
      for (k = 0; k < lit_count; k++) emit_byte(lit_buf[k]);
      lit_count = 0;
      gap_count = '0;
   endfunction

   function automatic void encode_transfer(input dre_pkg::req_type item);
      int               first_idx;
      dre_pkg::rsp_type tail;
      first_idx = encoded_bytes_q.size();
      if (item.row_byte == item.seed_byte) begin
         // a matching byte closes any open difference run
         if (lit_count > 0) emit_chunk();
         if (gap_count < GAP_CAP) gap_count++;
         else gap_count = GAP_CAP;
      end else begin
         if (lit_count >= dre_pkg::BUF_DEPTH) emit_chunk();
         lit_buf[lit_count % dre_pkg::BUF_DEPTH] = item.row_byte;
         lit_count++;
         if (lit_count >= dre_pkg::BUF_DEPTH) emit_chunk();
      end
      if (item.last_in_row) begin
         if (lit_count > 0) emit_chunk();
         if (encoded_bytes_q.size() == first_idx) begin
            // nothing sent by the row-end byte: empty marker with the row total
            tail                = '0;
            tail.encoded_length = row_len;
            encoded_bytes_q.push_back(tail);
         end
         tail          = encoded_bytes_q.pop_back();
         tail.row_done = 1'b1;
         encoded_bytes_q.push_back(tail);
         gap_count = '0;
         lit_count = 0;
         row_len   = '0;
      end
      if (encoded_bytes_q.size() > first_idx) begin
         tail             = encoded_bytes_q.pop_back();
         tail.last_of_run = 1'b1;
         encoded_bytes_q.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender. req_valid stays high from one transfer to the next unless an
   // idle cycle is inserted, so it is never lowered and raised in one step.
   // Anything that lets time pass between transfers must drop it first.
   // ---------------------------------------------------------------------
   task automatic send_byte(input dre_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_transfer(item);
   endtask

   task automatic send_pair(input logic [7:0] row_val, input logic [7:0] seed_val,
                            input logic last);
      dre_pkg::req_type item;
      item.row_byte    = row_val;
      item.seed_byte   = seed_val;
      item.last_in_row = last;
      send_byte(item);
   endtask

   // Random byte pair that either matches the seed or differs from it.
   function automatic dre_pkg::req_type make_pair(input bit same, input bit last);
      dre_pkg::req_type p;
      p.seed_byte   = 8'($urandom_range(255));
      p.row_byte    = same ? p.seed_byte : p.seed_byte ^ 8'($urandom_range(255, 1));
      p.last_in_row = last;
      return p;
   endfunction

   task automatic send_row(input int len, input int match_pct);
      int i;
      for (i = 0; i < len; i++)
         send_byte(make_pair($urandom_range(99) < match_pct, i == len - 1));
   endtask

   // Drop valid, then hold until every predicted byte has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (encoded_bytes_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: long hold-off when requested, otherwise random stalls.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Result checker: every accepted output transfer against the oldest
   // predicted byte, field by field.
   always @(posedge clock) begin
      dre_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (encoded_bytes_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("%0t: unexpected output transfer byte=%h valid=%b run=%b done=%b len=%0d",
                        $realtime, rsp_payload.out_byte, rsp_payload.out_valid,
                        rsp_payload.last_of_run, rsp_payload.row_done,
                        rsp_payload.encoded_length);
         end else begin
            want = encoded_bytes_q.pop_front();
            if (rsp_payload.out_byte       !== want.out_byte    ||
                rsp_payload.out_valid      !== want.out_valid   ||
                rsp_payload.last_of_run    !== want.last_of_run ||
                rsp_payload.row_done       !== want.row_done    ||
                rsp_payload.encoded_length !== want.encoded_length) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("%0t: mismatch byte=%h/%h valid=%b/%b run=%b/%b done=%b/%b len=%0d/%0d",
                           $realtime, want.out_byte, rsp_payload.out_byte,
                           want.out_valid, rsp_payload.out_valid,
                           want.last_of_run, rsp_payload.last_of_run,
                           want.row_done, rsp_payload.row_done,
                           want.encoded_length, rsp_payload.encoded_length);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes and each chunk trigger: empty row, single literal at row
   // end, run closed by a match, full buffer, continuation chunk at offset 0.
   task automatic test_directed();
      int k;
      send_idle_pct = 0;
      stall_pct     = 0;
      send_pair(8'h00, 8'h00, 1'b1);           // row without differences: marker, length 0
      send_pair(8'hFF, 8'h00, 1'b1);           // one literal flushed at row end
      send_pair(8'h00, 8'hFF, 1'b0);           // non-final byte, buffered, no output
      send_pair(8'hFF, 8'hFF, 1'b0);           // match closes the run
      send_pair(8'h07, 8'h07, 1'b1);           // row end with nothing pending: marker
      for (k = 0; k < 3; k++) send_pair(8'hA5, 8'hA5, 1'b0);
      for (k = 0; k < 8; k++) send_pair(8'(1 << k), 8'h00, 1'b0);  // buffer fills
      send_pair(8'h80, 8'h7F, 1'b1);           // next chunk of the same run, offset 0
      send_pair(8'h55, 8'hAA, 1'b0);
      send_pair(8'h3C, 8'h3C, 1'b0);
      send_pair(8'hC3, 8'h3C, 1'b1);
   endtask

   // Offsets around the inline limit of the command byte.
   task automatic test_offset_coding();
      int offsets [5] = '{0, 1, 30, 31, 32};
      int i;
      send_idle_pct = 0;
      stall_pct     = 0;
      for (i = 0; i < 5; i++) begin
         repeat (offsets[i]) send_byte(make_pair(1'b1, 1'b0));
         send_byte(make_pair(1'b0, 1'b1));
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering;
   // the descriptor queue fills and req_stall rises.
   task automatic test_hold_off();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_left = 400;
      repeat (3) send_row(10, 0);
      send_row(20, 40);
   endtask

   // Sender pauses with nothing in flight, then resumes mid-stream.
   task automatic test_drain_pause();
      send_idle_pct = 20;
      stall_pct     = 20;
      send_row(13, 30);
      wait_drained();
      send_row(9, 0);
      wait_drained();
      send_row(17, 60);
   endtask

   // Random rows: mostly short rows of mixed density, some single-byte rows
   // and now and then a longer, mostly matching row for extension bytes.
   task automatic test_random_rows(input int idle_pct, input int stall_in, input int n_items);
      int sent;
      int len;
      int match_pct;
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      sent          = 0;
      while (sent < n_items) begin
         case ($urandom_range(3))
            0:       match_pct = 0;
            1:       match_pct = 50;
            2:       match_pct = 85;
            default: match_pct = $urandom_range(100);
         endcase
         case ($urandom_range(19))
            0: begin
               len       = $urandom_range(64, 32);
               match_pct = 97;
            end
            1, 2:    len = 1;
            default: len = $urandom_range(24, 2);
         endcase
         send_row(len, match_pct);
         sent += len;
      end
   endtask

   initial begin
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_offset_coding();
      test_random_rows(0, 0, 40);     // no idling
      test_random_rows(65, 0, 40);    // sender mostly idle
      test_random_rows(0, 65, 40);    // receiver mostly stalling
      test_random_rows(6, 6, 40);     // light idling on both sides
      test_hold_off();
      test_drain_pause();

      stall_pct = 0;
      wait_drained();
      repeat (DRAIN_GUARD) @(posedge clock);
      if (encoded_bytes_q.size() != 0) fail_count++;

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/dre_pkg.sv
rtl/dre_front.sv
rtl/dre_queue.sv
rtl/dre_back.sv
rtl/delta_row_encoder.sv
sim/delta_row_encoder_tb.sv
